// ===== design/rmsf_pkg.sv =====
// ---------------------------------------------------------------------------
// rmsf_pkg - shared types and constants of the residue mask sieve filter
// Command codes, config register indices and the control bundle passed along
// the residue cell chain.
package rmsf_pkg;

  localparam int NUM_TABLES   = 8;
  localparam int RESIDUE_SPAN = 32;

  localparam logic [1:0] CMD_WR_PRIME = 2'd0;
  localparam logic [1:0] CMD_WR_ENTRY = 2'd1;
  localparam logic [1:0] CMD_TEST     = 2'd2;
  localparam logic [1:0] CMD_RSVD     = 2'd3;

  localparam logic [1:0] CFG_GROUP  = 2'd0;
  localparam logic [1:0] CFG_CURVE  = 2'd1;
  localparam logic [1:0] CFG_TABLES = 2'd2;
  localparam logic [1:0] CFG_RSVD   = 2'd3;

  // control bundle shifted down the cell chain with the operand bits
  typedef struct packed {
    logic load;   // first cycle: clear the remainders
    logic shift;  // one dividend bit enters each cell
  } cell_ctrl_t;

endpackage

// ===== design/rmsf_cell.sv =====
// ---------------------------------------------------------------------------
// rmsf_cell - one residue cell
// Holds the running remainder of the magnitude and of the denominator by a
// single prime, one dividend bit per cycle while shift is set, MSB first.
// Bits pass on to the next cell through a register.
// ---------------------------------------------------------------------------
module rmsf_cell (
  input  logic                clk,
  input  logic [4:0]          prime,
  input  rmsf_pkg::cell_ctrl_t ctrl_in,
  input  logic                mag_bit_in,
  input  logic                den_bit_in,
  output rmsf_pkg::cell_ctrl_t ctrl_out,
  output logic                mag_bit_out,
  output logic                den_bit_out,
  output logic [4:0]          rem_mag,
  output logic [4:0]          rem_den
);

  logic [4:0] mag_base;
  logic [4:0] den_base;
  logic [5:0] mag_next;
  logic [5:0] den_next;

  // the load beat restarts from zero but still takes the bit on the wire
  always_comb begin
    mag_base = ctrl_in.load ? 5'd0 : rem_mag;
    den_base = ctrl_in.load ? 5'd0 : rem_den;
    mag_next = {mag_base, mag_bit_in};
    den_next = {den_base, den_bit_in};
    if (prime != 5'd0 && mag_next >= {1'b0, prime}) mag_next = mag_next - {1'b0, prime};
    if (prime != 5'd0 && den_next >= {1'b0, prime}) den_next = den_next - {1'b0, prime};
  end

  always_ff @(posedge clk) begin
    ctrl_out    <= ctrl_in;
    mag_bit_out <= mag_bit_in;
    den_bit_out <= den_bit_in;
    if (ctrl_in.shift) begin
      rem_mag <= mag_next[4:0];
      rem_den <= den_next[4:0];
    end else if (ctrl_in.load) begin
      rem_mag <= 5'd0;
      rem_den <= 5'd0;
    end
  end

endmodule

// ===== design/rmsf_gcd.sv =====
// ---------------------------------------------------------------------------
// rmsf_gcd - binary gcd unit
// Stein's algorithm, one step per cycle; flags whether the pair is coprime.
// ---------------------------------------------------------------------------
module rmsf_gcd (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [31:0] a_in,
  input  logic [30:0] b_in,
  output logic        done,
  output logic        coprime
);

  logic [31:0] a;
  logic [31:0] b;
  logic        both_even;
  logic        running;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        a         <= a_in;
        b         <= {1'b0, b_in};
        both_even <= 1'b0;
        running   <= 1'b1;
      end else if (running) begin
        if (a == 32'd0 || b == 32'd0) begin
          running <= 1'b0;
          done    <= 1'b1;
          coprime <= !both_even && ((a | b) == 32'd1);
        end else if (!a[0] && !b[0]) begin
          both_even <= 1'b1;
          a <= a >> 1;
          b <= b >> 1;
        end else if (!a[0]) begin
          a <= a >> 1;
        end else if (!b[0]) begin
          b <= b >> 1;
        end else if (a >= b) begin
          a <= (a - b) >> 1;
        end else begin
          b <= (b - a) >> 1;
        end
      end
    end
  end

endmodule

// ===== design/residue_mask_sieve_filter_unit.sv =====
// ---------------------------------------------------------------------------
// residue_mask_sieve_filter_unit - residue mask sieve filter, top level
// Loads prime tables and mask entries; tests numerator/denominator pairs.
// ---------------------------------------------------------------------------
// Write commands never raise busy. While a test holds busy high, a chain of
// residue cells (one per table) reduces both operands one bit per cycle, in
// parallel with a binary gcd unit; a pair that is not coprime then goes
// straight to the result. Otherwise one mask read per table in use follows on
// the single mask memory port, then the remainder of the lowest surviving bit
// by the group width is formed, and then the group check. The result shows
// for one cycle with done, in the same cycle as busy falls; the receiver
// cannot stall it.
module residue_mask_sieve_filter_unit #(
  parameter int MASK_BITS    = 128
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  output logic         busy,
  input  logic [1:0]   command,
  input  logic [2:0]   table_select,
  input  logic [4:0]   prime_value,
  input  logic [4:0]   residue_num,
  input  logic [4:0]   residue_den,
  input  logic [63:0]  entry_low,
  input  logic [63:0]  entry_high,
  input  logic signed [31:0] numerator,
  input  logic [30:0]  denominator,
  output logic         done,
  output logic         is_primitive,
  output logic         is_candidate,
  output logic [63:0]  survivor_low,
  output logic [63:0]  survivor_high,
  output logic signed [31:0] echo_numerator,
  output logic [30:0]  echo_denominator,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [7:0]   cfg_data
);

  localparam int NUM_TABLES   = rmsf_pkg::NUM_TABLES;
  localparam int RESIDUE_SPAN = rmsf_pkg::RESIDUE_SPAN;
  localparam int TW   = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
  localparam int RW   = $clog2(RESIDUE_SPAN);
  localparam int AW   = TW + 2 * RW;
  localparam int DEPTH = NUM_TABLES * RESIDUE_SPAN * RESIDUE_SPAN;
  localparam int BW   = $clog2(MASK_BITS);
  localparam int NBW  = $clog2(NUM_TABLES + 1);
  localparam int SHW  = 6;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_REDUCE = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_AND   = 3'd3;
  localparam logic [2:0] ST_CHECK = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;
  localparam logic [2:0] ST_GROUP = 3'd6;

  logic [2:0] state;
  logic [6:0] group_size;
  logic [7:0] curve_total;
  logic [3:0] tables_used;

  logic [4:0] primes [NUM_TABLES];
  logic [MASK_BITS-1:0] mask_mem [DEPTH];
  logic [MASK_BITS-1:0] rd_data;
  logic [AW-1:0] rd_addr;
  logic [127:0] wr_entry;

  logic [31:0] mag;
  logic [31:0] mag_sh;
  logic [30:0] den_sh;
  logic        neg;
  logic [SHW:0] shcnt;
  logic [NBW-1:0] tcnt;
  logic [NBW-1:0] ntab;
  logic [127:0] mask;
  logic gcd_go, gcd_done, gcd_cop, gcd_seen, cop;

  rmsf_pkg::cell_ctrl_t ctrl [NUM_TABLES+1];
  logic mbit [NUM_TABLES+1];
  logic dbit [NUM_TABLES+1];
  logic [4:0] rmag [NUM_TABLES];
  logic [4:0] rden [NUM_TABLES];

  assign cfg_ready = (state == ST_IDLE) && !start;
  assign busy      = (state != ST_IDLE);

  assign mag = numerator[31] ? (32'd0 - numerator) : numerator;

  // operands come from the registered copies; the ports may already move on
  rmsf_gcd u_gcd (
    .clk(clk), .rst(rst), .go(gcd_go), .a_in(mag_sh), .b_in(den_sh),
    .done(gcd_done), .coprime(gcd_cop)
  );

  assign ctrl[0].load  = gcd_go;
  assign ctrl[0].shift = (state == ST_REDUCE) && (shcnt < 7'd32);
  assign mbit[0] = mag_sh[31];
  assign dbit[0] = (shcnt == 7'd0) ? 1'b0 : den_sh[30];

  for (genvar i = 0; i < NUM_TABLES; i++) begin : g_cell
    rmsf_cell u_cell (
      .clk(clk), .prime(primes[i]), .ctrl_in(ctrl[i]),
      .mag_bit_in(mbit[i]), .den_bit_in(dbit[i]), .ctrl_out(ctrl[i+1]),
      .mag_bit_out(mbit[i+1]), .den_bit_out(dbit[i+1]),
      .rem_mag(rmag[i]), .rem_den(rden[i])
    );
  end

  // residues of the current table; a zero prime addresses residue pair 0/0
  logic [TW-1:0] tix;
  logic [4:0] p_t, ra, rb;
  logic skip;
  always_comb begin
    tix  = tcnt[TW-1:0];
    p_t  = primes[tix];
    if (p_t == 5'd0) begin
      ra = 5'd0;
      rb = 5'd0;
    end else begin
      rb = rden[tix];
      ra = (neg && rmag[tix] != 5'd0) ? (p_t - rmag[tix]) : rmag[tix];
    end
    skip = ({27'd0, ra} >= 32'(RESIDUE_SPAN)) || ({27'd0, rb} >= 32'(RESIDUE_SPAN));
    rd_addr = {tix, ra[RW-1:0], rb[RW-1:0]};
  end

  assign wr_entry = {entry_high, entry_low};

  always_ff @(posedge clk) begin
    if (start && !busy && command == rmsf_pkg::CMD_WR_ENTRY &&
        {29'd0, table_select} < 32'(NUM_TABLES) &&
        {27'd0, residue_num} < 32'(RESIDUE_SPAN) &&
        {27'd0, residue_den} < 32'(RESIDUE_SPAN))
      mask_mem[{table_select[TW-1:0], residue_num[RW-1:0], residue_den[RW-1:0]}] <=
        wr_entry[MASK_BITS-1:0];
    if (state == ST_READ) rd_data <= mask_mem[rd_addr];
  end

  // group check on the survivors; the group start is first minus first mod g
  logic [BW:0] first;
  logic [6:0] g;
  logic [127:0] gmask;
  logic [7:0] gbeg;
  logic [BW:0] fsh;
  logic [3:0] gcnt;
  logic [6:0] grem;
  logic [7:0] grem_sh;
  logic [7:0] grem_diff;
  logic [6:0] grem_next;
  always_comb begin
    first = '0;
    for (int k = MASK_BITS - 1; k >= 0; k--)
      if (mask[k]) first = (BW+1)'(k);
    g = (group_size == 7'd0) ? 7'd1 : group_size;
    grem_sh   = {grem, fsh[BW]};
    grem_diff = grem_sh - {1'b0, g};
    grem_next = (grem_sh >= {1'b0, g}) ? grem_diff[6:0] : grem_sh[6:0];
    gbeg = 8'(first) - {1'b0, grem};
    gmask = '0;
    for (int k = 0; k < 128; k++)
      gmask[k] = (k >= gbeg) && (k < gbeg + g);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      group_size <= 7'd1;
      curve_total <= 8'd128;
      tables_used <= 4'd1;
      done <= 1'b0;
      gcd_go <= 1'b0;
    end else begin
      done   <= 1'b0;
      gcd_go <= 1'b0;
      if (gcd_done) begin
        gcd_seen <= 1'b1;
        cop <= gcd_cop;
      end
      case (state)
        ST_IDLE: begin
          if (cfg_valid && cfg_ready) begin
            case (cfg_index)
              rmsf_pkg::CFG_GROUP:  group_size  <= cfg_data[6:0];
              rmsf_pkg::CFG_CURVE:  curve_total <= cfg_data;
              rmsf_pkg::CFG_TABLES: tables_used <= cfg_data[3:0];
              default: ;
            endcase
          end
          if (start) begin
            if (command == rmsf_pkg::CMD_WR_PRIME &&
                {29'd0, table_select} < 32'(NUM_TABLES))
              primes[table_select[TW-1:0]] <= prime_value;
            if (command == rmsf_pkg::CMD_TEST) begin
              echo_numerator   <= numerator;
              echo_denominator <= denominator;
              neg      <= numerator[31];
              mag_sh   <= mag;
              den_sh   <= denominator;
              shcnt    <= '0;
              gcd_go   <= 1'b1;
              gcd_seen <= 1'b0;
              ntab <= ({28'd0, tables_used} > 32'(NUM_TABLES)) ?
                      NBW'(NUM_TABLES) : tables_used[NBW-1:0];
              for (int k = 0; k < 128; k++)
                mask[k] <= (k < MASK_BITS) && (k < curve_total);
              state <= ST_REDUCE;
            end
          end
        end
        ST_REDUCE: begin
          if (shcnt < 7'd32) begin
            mag_sh <= mag_sh << 1;
            if (shcnt != 7'd0) den_sh <= den_sh << 1;
          end
          if (shcnt < 7'(32 + NUM_TABLES + 1)) shcnt <= shcnt + 7'd1;
          else if (gcd_seen) begin
            tcnt <= '0;
            if (!cop) begin
              is_primitive <= 1'b0;
              is_candidate <= 1'b0;
              survivor_low <= '0;
              survivor_high <= '0;
              state <= ST_OUT;
            end else state <= ST_READ;
          end
        end
        ST_READ: begin
          if (tcnt >= ntab) begin
            fsh   <= first;
            grem  <= '0;
            gcnt  <= 4'(BW);
            state <= ST_GROUP;
          end else if (skip) tcnt <= tcnt + 1'b1;
          else state <= ST_AND;
        end
        ST_AND: begin
          mask[MASK_BITS-1:0] <= mask[MASK_BITS-1:0] & rd_data;
          tcnt  <= tcnt + 1'b1;
          state <= ST_READ;
        end
        // first mod g, one compare and subtract per bit, MSB first
        ST_GROUP: begin
          grem <= grem_next;
          fsh  <= fsh << 1;
          if (gcnt == 4'd0) state <= ST_CHECK;
          else gcnt <= gcnt - 4'd1;
        end
        ST_CHECK: begin
          is_primitive  <= 1'b1;
          is_candidate  <= (mask != '0) && ((mask & ~gmask) != '0);
          survivor_low  <= mask[63:0];
          survivor_high <= mask[127:64];
          state <= ST_OUT;
        end
        ST_OUT: begin
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_done_one: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held two cycles");
  a_no_cfg_busy: assert property (@(posedge clk) disable iff (rst) busy |-> !cfg_ready)
    else $error("config accepted while busy");
  a_prim: assert property (@(posedge clk) disable iff (rst)
    done && !is_primitive |-> !is_candidate && survivor_low == 64'd0)
    else $error("non-primitive result carries mask");

endmodule

// ===== test/residue_mask_sieve_filter_unit_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// residue_mask_sieve_filter_unit_tb - self-checking bench for the sieve filter
// Loads prime tables and mask entries on demand, tests numerator/denominator
// pairs under several register settings and idle patterns, and compares each
// result beat with a behavioural prediction held in a scoreboard.
// ---------------------------------------------------------------------------
module residue_mask_sieve_filter_unit_tb;

  localparam int TBL_CNT   = 8;
  localparam int SPAN      = 32;
  localparam int STALL_MAX = 20000;
  localparam int PHASE_LEN = 160;
  localparam int DRAIN_CYC = 150;

  typedef struct {
    logic [1:0]         cmd;
    logic [2:0]         sel;
    logic [4:0]         prime;
    logic [4:0]         rn;
    logic [4:0]         rd;
    logic [63:0]        lo;
    logic [63:0]        hi;
    logic signed [31:0] num;
    logic [30:0]        den;
  } sieve_item_t;

  typedef struct {
    logic               prim;
    logic               cand;
    logic [63:0]        lo;
    logic [63:0]        hi;
    logic signed [31:0] num;
    logic [30:0]        den;
  } sieve_verdict_t;

  class sieve_scoreboard;
    logic [4:0]     primes[TBL_CNT];
    bit             prime_set[TBL_CNT];
    logic [63:0]    store_lo[TBL_CNT*SPAN*SPAN];
    logic [63:0]    store_hi[TBL_CNT*SPAN*SPAN];
    bit             entry_set[TBL_CNT*SPAN*SPAN];
    int unsigned    group_reg = 1;
    int unsigned    curve_reg = 128;
    int unsigned    tables_reg = 1;
    sieve_verdict_t pending[$];
    int             errors;
    int             checked;
    int             primitive_cnt;
    int             candidate_cnt;

    function void set_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        rmsf_pkg::CFG_GROUP:  group_reg = val & 8'h7F;
        rmsf_pkg::CFG_CURVE:  curve_reg = val;
        rmsf_pkg::CFG_TABLES: tables_reg = val & 8'h0F;
        default: ;
      endcase
    endfunction

    function int unsigned tables_in_use();
      return (tables_reg > TBL_CNT) ? TBL_CNT : tables_reg;
    endfunction

    // residue address of table t for the pair; -1 when the table is skipped
    function int entry_addr(int t, logic [31:0] nf, logic [30:0] den);
      longint unsigned mag, p, r, a, b;
      mag = nf[31] ? (64'h1_0000_0000 - {32'b0, nf}) : {32'b0, nf};
      p = primes[t];
      a = 0;
      b = 0;
      if (p != 0) begin
        r = mag % p;
        a = (nf[31] && r != 0) ? p - r : r;
        b = den % p;
      end
      if (a >= SPAN || b >= SPAN) return -1;
      return (t * SPAN + int'(a)) * SPAN + int'(b);
    endfunction

    function void note_item(sieve_item_t it);
      sieve_verdict_t v;
      longint unsigned x, y, tmp;
      logic [127:0] m, grp;
      int unsigned g, ct, first;
      int ad;
      case (it.cmd)
        rmsf_pkg::CMD_WR_PRIME: begin
          primes[it.sel] = it.prime;
          prime_set[it.sel] = 1;
        end
        rmsf_pkg::CMD_WR_ENTRY: begin
          ad = (it.sel * SPAN + it.rn) * SPAN + it.rd;
          store_lo[ad] = it.lo;
          store_hi[ad] = it.hi;
          entry_set[ad] = 1;
        end
        rmsf_pkg::CMD_TEST: begin
          v.num = it.num;
          v.den = it.den;
          x = it.num[31] ? (64'h1_0000_0000 - {32'b0, it.num}) : {32'b0, it.num};
          y = it.den;
          while (y != 0) begin
            tmp = x % y;
            x = y;
            y = tmp;
          end
          v.prim = (x == 1);
          m = '0;
          v.cand = 0;
          if (v.prim) begin
            ct = (curve_reg > 128) ? 128 : curve_reg;
            m = (ct == 128) ? '1 : ((128'd1 << ct) - 1);
            for (int t = 0; t < tables_in_use(); t++) begin
              ad = entry_addr(t, it.num, it.den);
              if (ad >= 0) m &= {store_hi[ad], store_lo[ad]};
            end
            g = (group_reg == 0) ? 1 : group_reg;
            if (m != 0) begin
              first = 0;
              while (!m[first]) first++;
              grp = '0;
              for (int i = (first / g) * g; i < (first / g) * g + g && i < 128; i++)
                grp[i] = 1'b1;
              v.cand = |(m & ~grp);
            end
          end
          v.lo = m[63:0];
          v.hi = m[127:64];
          pending = {pending, v};
        end
        default: ;
      endcase
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH %s: got %h want %h (result %0d)", what, got, want, checked);
      errors++;
    endtask

    task check_result(sieve_verdict_t r);
      sieve_verdict_t e;
      if (pending.size() == 0) begin
        report("unexpected result beat", r.lo, 0);
        return;
      end
      e = pending.pop_front();
      checked++;
      if (r.prim) primitive_cnt++;
      if (r.cand) candidate_cnt++;
      if (r.prim !== e.prim) report("is_primitive", r.prim, e.prim);
      if (r.cand !== e.cand) report("is_candidate", r.cand, e.cand);
      if (r.lo !== e.lo)     report("survivor_low", r.lo, e.lo);
      if (r.hi !== e.hi)     report("survivor_high", r.hi, e.hi);
      if (r.num !== e.num)   report("echo_numerator", r.num, e.num);
      if (r.den !== e.den)   report("echo_denominator", r.den, e.den);
    endtask
  endclass

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [1:0]         command;
  logic [2:0]         table_select;
  logic [4:0]         prime_value;
  logic [4:0]         residue_num;
  logic [4:0]         residue_den;
  logic [63:0]        entry_low;
  logic [63:0]        entry_high;
  logic signed [31:0] numerator;
  logic [30:0]        denominator;
  logic               done;
  logic               is_primitive;
  logic               is_candidate;
  logic [63:0]        survivor_low;
  logic [63:0]        survivor_high;
  logic signed [31:0] echo_numerator;
  logic [30:0]        echo_denominator;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [7:0]         cfg_data;

  sieve_scoreboard sb;
  int sent_items;
  int test_items;
  int gap_pct;
  int stall_cnt;

  residue_mask_sieve_filter_unit u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .command(command), .table_select(table_select), .prime_value(prime_value),
    .residue_num(residue_num), .residue_den(residue_den),
    .entry_low(entry_low), .entry_high(entry_high),
    .numerator(numerator), .denominator(denominator),
    .done(done), .is_primitive(is_primitive), .is_candidate(is_candidate),
    .survivor_low(survivor_low), .survivor_high(survivor_high),
    .echo_numerator(echo_numerator), .echo_denominator(echo_denominator),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // result beats are taken at the edge that ends their cycle
  always @(posedge clk) begin
    sieve_verdict_t r;
    if (!rst && done) begin
      r.prim = is_primitive;
      r.cand = is_candidate;
      r.lo   = survivor_low;
      r.hi   = survivor_high;
      r.num  = echo_numerator;
      r.den  = echo_denominator;
      sb.check_result(r);
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || (cfg_valid && cfg_ready) || done) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_MAX) begin
      $display("timeout: no beat for %0d cycles", STALL_MAX);
      $display("residue_mask_sieve_filter_unit_tb: FAIL");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  function automatic logic [63:0] rand_mask();
    logic [63:0] a, b, c;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    c = {$urandom, $urandom};
    case ($urandom_range(3))
      0: return '1;
      1: return a | b;
      2: return a;
      default: return a | b | c;
    endcase
  endfunction

  function automatic sieve_item_t rand_item(logic [1:0] cmd);
    sieve_item_t it;
    it.cmd   = cmd;
    it.sel   = 3'($urandom);
    it.prime = 5'($urandom);
    it.rn    = 5'($urandom);
    it.rd    = 5'($urandom);
    it.lo    = rand_mask();
    it.hi    = rand_mask();
    it.num   = $urandom;
    it.den   = 31'($urandom);
    return it;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(sieve_item_t it);
    if ($urandom_range(99) < gap_pct) begin
      start = 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    command      = it.cmd;
    table_select = it.sel;
    prime_value  = it.prime;
    residue_num  = it.rn;
    residue_den  = it.rd;
    entry_low    = it.lo;
    entry_high   = it.hi;
    numerator    = it.num;
    denominator  = it.den;
    start        = 1;
    while (busy) @(negedge clk);
    sb.note_item(it);
    sent_items++;
    if (it.cmd == rmsf_pkg::CMD_TEST) test_items++;
    @(negedge clk);
  endtask

  // loads any prime or entry the pair would read that was never written
  task automatic send_test(logic signed [31:0] num, logic [30:0] den);
    sieve_item_t it;
    int ad;
    for (int t = 0; t < sb.tables_in_use(); t++) begin
      if (!sb.prime_set[t]) begin
        it = rand_item(rmsf_pkg::CMD_WR_PRIME);
        it.sel = 3'(t);
        send_item(it);
      end
      ad = sb.entry_addr(t, num, den);
      if (ad >= 0 && !sb.entry_set[ad]) begin
        it = rand_item(rmsf_pkg::CMD_WR_ENTRY);
        it.sel = 3'(t);
        it.rn = 5'((ad / SPAN) % SPAN);
        it.rd = 5'(ad % SPAN);
        send_item(it);
      end
    end
    it = rand_item(rmsf_pkg::CMD_TEST);
    it.num = num;
    it.den = den;
    send_item(it);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    start = 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
    while (busy) @(negedge clk);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data  = val;
    while (!cfg_ready) @(negedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic rand_pair(output logic signed [31:0] num, output logic [30:0] den);
    case ($urandom_range(9))
      0, 1, 2, 3: num = $signed($urandom_range(100)) - 50;
      4, 5, 6:    num = $urandom;
      7:          num = $signed($urandom_range(20)) * 6;
      8:          num = 32'sh8000_0000;
      default:    num = $urandom_range(1) ? 32'sh7FFF_FFFF : -32'sd1;
    endcase
    case ($urandom_range(9))
      0, 1, 2, 3, 4: den = 31'($urandom_range(1, 60));
      5, 6, 7:       den = 31'($urandom);
      8:             den = $urandom_range(1) ? 31'h7FFF_FFFF : 31'd1;
      default:       den = $urandom_range(1) ? 31'd0 : 31'd6 * 31'($urandom_range(1, 9));
    endcase
  endtask

  initial begin
    sieve_item_t it;
    logic signed [31:0] n;
    logic [30:0] d;
    int unsigned phase_cfg[7][3] = '{
      '{1, 128, 8}, '{0, 255, 15}, '{127, 1, 4}, '{4, 100, 3},
      '{64, 128, 8}, '{8, 64, 0}, '{2, 127, 8}};
    logic [4:0] first_primes[TBL_CNT] = '{2, 3, 5, 7, 31, 0, 1, 13};
    int mark;

    sb = new();
    rst = 1; start = 0; cfg_valid = 0; cfg_index = '0; cfg_data = '0;
    command = '0; table_select = '0; prime_value = '0; residue_num = '0;
    residue_den = '0; entry_low = '0; entry_high = '0;
    numerator = '0; denominator = '0;
    stall_cnt = 0; sent_items = 0; test_items = 0; gap_pct = 25;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: table primes, an unknown command and corner pairs
    for (int t = 0; t < TBL_CNT; t++) begin
      it = rand_item(rmsf_pkg::CMD_WR_PRIME);
      it.sel = 3'(t);
      it.prime = first_primes[t];
      send_item(it);
    end
    send_item(rand_item(rmsf_pkg::CMD_RSVD));
    send_test(32'sd0, 31'd1);
    send_test(32'sd1, 31'd0);
    send_test(-32'sd1, 31'd0);
    send_test(32'sd0, 31'd0);
    send_test(32'sh8000_0000, 31'h7FFF_FFFF);
    send_test(32'sh8000_0000, 31'd1);
    send_test(32'sh7FFF_FFFF, 31'd1);
    send_test(32'sd6, 31'd4);
    send_test(-32'sd7, 31'd3);
    send_test(32'sd12345, 31'h7FFF_FFFF);
    write_reg(rmsf_pkg::CFG_RSVD, 8'hFF);

    for (int p = 0; p < 7; p++) begin
      write_reg(rmsf_pkg::CFG_GROUP, 8'(phase_cfg[p][0]));
      write_reg(rmsf_pkg::CFG_CURVE, 8'(phase_cfg[p][1]));
      write_reg(rmsf_pkg::CFG_TABLES, 8'(phase_cfg[p][2]));
      gap_pct = (p < 3) ? 25 : (p < 5) ? 60 : 0;
      mark = sent_items;
      while (sent_items - mark < PHASE_LEN) begin
        case ($urandom_range(99)) inside
          [0:11]: send_item(rand_item(rmsf_pkg::CMD_WR_ENTRY));
          [12:17]: begin
            it = rand_item(rmsf_pkg::CMD_WR_PRIME);
            if ($urandom_range(3) != 0) it.prime = 5'($urandom_range(2, 7));
            send_item(it);
          end
          [18:21]: send_item(rand_item(rmsf_pkg::CMD_RSVD));
          default: begin
            rand_pair(n, d);
            send_test(n, d);
          end
        endcase
      end
    end

    start = 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
    $display("covered %0d items, %0d pair tests, 7 register settings", sent_items, test_items);
    $display("results checked %0d: %0d primitive, %0d candidates, %0d mismatches",
             sb.checked, sb.primitive_cnt, sb.candidate_cnt, sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("residue_mask_sieve_filter_unit_tb: PASS");
    end else begin
      $display("residue_mask_sieve_filter_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/rmsf_pkg.sv
design/rmsf_cell.sv
design/rmsf_gcd.sv
design/residue_mask_sieve_filter_unit.sv
test/residue_mask_sieve_filter_unit_tb.sv
